// ===== design/ssdt_pkg.sv =====
package ssdt_pkg;

    localparam int COORD_W   = 4;
    localparam int SIZE_W    = 5;
    localparam int DIST_W    = 9;
    localparam int RAD_W     = 5;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_LIM = 16;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_ACC   = 6'b001000,
        S_DRAIN = 6'b010000,
        S_WB    = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        P_Z = 3'b001,
        P_Y = 3'b010,
        P_X = 3'b100
    } t_pass;

    typedef struct packed {
        logic occ;
        logic zp;
        logic yp;
        logic dmap;
    } t_we;

    // floor(sqrt(d)) - 1: count the squares 1..16 that do not exceed d
    function automatic logic signed [RAD_W-1:0] empty_radius(input logic [DIST_W-1:0] d);
        logic [RAD_W-1:0] root;
        root = '0;
        for (int k = 1; k <= COORD_LIM; k++) begin
            if (d >= DIST_W'(k * k)) begin
                root = root + RAD_W'(1);
            end
        end
        return $signed(root - RAD_W'(1));
    endfunction

endpackage

// ===== design/ssdt_store.sv =====
module ssdt_store
    import ssdt_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_raddr,
    input  logic [AW-1:0]     i_waddr,
    input  t_we               i_we,
    input  logic              i_occ_wdata,
    input  logic [DIST_W-1:0] i_wdata,
    output logic              o_occ,
    output logic [DIST_W-1:0] o_zp,
    output logic [DIST_W-1:0] o_yp,
    output logic [DIST_W-1:0] o_dist
);

    localparam int DEPTH = 1 << AW;

    logic              mem_occ  [DEPTH];
    logic [DIST_W-1:0] mem_zp   [DEPTH];
    logic [DIST_W-1:0] mem_yp   [DEPTH];
    logic [DIST_W-1:0] mem_dist [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.occ) begin
            mem_occ[i_waddr] <= i_occ_wdata;
        end
        o_occ <= mem_occ[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.zp) begin
            mem_zp[i_waddr] <= i_wdata;
        end
        o_zp <= mem_zp[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.yp) begin
            mem_yp[i_waddr] <= i_wdata;
        end
        o_yp <= mem_yp[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.dmap) begin
            mem_dist[i_waddr] <= i_wdata;
        end
        o_dist <= mem_dist[i_raddr];
    end

endmodule

// ===== design/ssdt_min_unit.sv =====
module ssdt_min_unit
    import ssdt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_clear,
    input  logic [SIZE_W-1:0]  i_init_size,
    input  logic               i_acc,
    input  logic               i_cand,
    input  logic [DIST_W-1:0]  i_src,
    input  logic [COORD_W-1:0] i_a,
    input  logic [COORD_W-1:0] i_b,
    output logic [DIST_W-1:0]  o_best
);

    logic [DIST_W-1:0]    r_best;
    logic [DIST_W-1:0]    n_best;
    logic [COORD_W-1:0]   diff;
    logic [2*COORD_W-1:0] sq;
    logic [DIST_W:0]      sum;
    logic [2*SIZE_W-1:0]  init_sq;

    assign diff    = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
    assign sq      = {{COORD_W{1'b0}}, diff} * {{COORD_W{1'b0}}, diff};
    assign sum     = {1'b0, i_src} + (DIST_W+1)'(sq);
    assign init_sq = {{SIZE_W{1'b0}}, i_init_size} * {{SIZE_W{1'b0}}, i_init_size};

    always_comb begin
        n_best = r_best;
        priority if (i_clear) begin
            n_best = init_sq[DIST_W-1:0];
        end else if (i_acc && i_cand && (sum < {1'b0, r_best})) begin
            n_best = sum[DIST_W-1:0];
        end else begin
            n_best = r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_best = r_best;

endmodule

// ===== design/separable_squared_distance_transform_unit.sv =====
// Voxel squared distance transform. A transaction is taken when start is high and busy is
// low. A write (occupancy) or an unknown command gives its zero result strobe on o_done in
// the next cycle and another command may follow at once. A read holds busy in S_READ while
// the distance memory answers, then strobes the distance and radius. A run with a zero size
// strobes like a write; otherwise it holds busy, paced by the single add/compare unit that
// folds one candidate per cycle in S_ACC, with a registered memory read and one write-back
// per voxel in each of the three passes; the strobe follows in the next cycle. After reset
// the block is busy while it clears the occupancy and distance memories; size registers may
// be written then. The o_done strobe is high for a single cycle and cannot be held off; the
// distance and radius stay on the ports until the next transaction is taken.
module separable_squared_distance_transform_unit
    import ssdt_pkg::*;
#(
    parameter int MAX_X = 16,
    parameter int MAX_Y = 16,
    parameter int MAX_Z = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [COORD_W-1:0]       i_coord_x,
    input  logic [COORD_W-1:0]       i_coord_y,
    input  logic [COORD_W-1:0]       i_coord_z,
    input  logic                     i_occupied,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [SIZE_W-1:0]        i_cfg_data,
    output logic                     o_done,
    output logic [DIST_W-1:0]        o_sq_distance,
    output logic signed [RAD_W-1:0]  o_empty_radius
);

    localparam int LIM_X = (MAX_X < COORD_LIM) ? MAX_X : COORD_LIM;
    localparam int LIM_Y = (MAX_Y < COORD_LIM) ? MAX_Y : COORD_LIM;
    localparam int LIM_Z = (MAX_Z < COORD_LIM) ? MAX_Z : COORD_LIM;
    localparam int CW_X  = $clog2(LIM_X);
    localparam int CW_Y  = $clog2(LIM_Y);
    localparam int CW_Z  = $clog2(LIM_Z);
    localparam int AW    = CW_X + CW_Y + CW_Z;

    t_state                   r_state, n_state;
    t_pass                    r_pass, n_pass;
    logic [SIZE_W-1:0]        r_size_x, r_size_y, r_size_z;
    logic [COORD_W-1:0]       r_x, n_x, r_y, n_y, r_z, n_z, r_l, n_l;
    logic [COORD_W-1:0]       r_l_d;
    logic                     r_pv, n_pv;
    logic [AW-1:0]            r_clr_addr, n_clr_addr;
    logic                     r_done, n_done;
    logic [DIST_W-1:0]        r_sq, n_sq;
    logic signed [RAD_W-1:0]  r_rad, n_rad;
    logic                     r_rd_inside, n_rd_inside;

    logic [SIZE_W-1:0]        eff_x, eff_y, eff_z, s_axis;
    logic [COORD_W-1:0]       c_axis;
    logic                     in_grid, accept;
    logic                     l_last, x_last, y_last, z_last;
    logic [AW-1:0]            in_addr, cell_addr, pass_addr, raddr, waddr;
    t_we                      we;
    logic                     occ_wdata;
    logic [DIST_W-1:0]        wdata;
    logic                     occ_rd;
    logic [DIST_W-1:0]        zp_rd, yp_rd, dist_rd, best;
    logic                     cand;
    logic [DIST_W-1:0]        src;

    assign eff_x = (r_size_x > SIZE_W'(LIM_X)) ? SIZE_W'(LIM_X) : r_size_x;
    assign eff_y = (r_size_y > SIZE_W'(LIM_Y)) ? SIZE_W'(LIM_Y) : r_size_y;
    assign eff_z = (r_size_z > SIZE_W'(LIM_Z)) ? SIZE_W'(LIM_Z) : r_size_z;

    assign in_grid = ({1'b0, i_coord_x} < eff_x) && ({1'b0, i_coord_y} < eff_y)
                  && ({1'b0, i_coord_z} < eff_z);
    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;

    assign in_addr   = {i_coord_x[CW_X-1:0], i_coord_y[CW_Y-1:0], i_coord_z[CW_Z-1:0]};
    assign cell_addr = {r_x[CW_X-1:0], r_y[CW_Y-1:0], r_z[CW_Z-1:0]};

    always_comb begin
        unique case (r_pass)
            P_Z: begin
                s_axis    = eff_z;
                c_axis    = r_z;
                pass_addr = {r_x[CW_X-1:0], r_y[CW_Y-1:0], r_l[CW_Z-1:0]};
                cand      = occ_rd;
                src       = '0;
            end
            P_Y: begin
                s_axis    = eff_y;
                c_axis    = r_y;
                pass_addr = {r_x[CW_X-1:0], r_l[CW_Y-1:0], r_z[CW_Z-1:0]};
                cand      = 1'b1;
                src       = zp_rd;
            end
            P_X: begin
                s_axis    = eff_x;
                c_axis    = r_x;
                pass_addr = {r_l[CW_X-1:0], r_y[CW_Y-1:0], r_z[CW_Z-1:0]};
                cand      = 1'b1;
                src       = yp_rd;
            end
            default: begin
                s_axis    = eff_z;
                c_axis    = r_z;
                pass_addr = cell_addr;
                cand      = 1'b0;
                src       = '0;
            end
        endcase
    end

    assign l_last = ({1'b0, r_l} == (s_axis - SIZE_W'(1)));
    assign x_last = ({1'b0, r_x} == (eff_x - SIZE_W'(1)));
    assign y_last = ({1'b0, r_y} == (eff_y - SIZE_W'(1)));
    assign z_last = ({1'b0, r_z} == (eff_z - SIZE_W'(1)));

    assign raddr = (r_state == S_IDLE) ? in_addr : pass_addr;

    always_comb begin
        we        = '0;
        waddr     = cell_addr;
        occ_wdata = 1'b0;
        wdata     = best;
        unique case (r_state)
            S_CLEAR: begin
                we.occ  = 1'b1;
                we.dmap = 1'b1;
                waddr   = r_clr_addr;
                wdata   = '0;
            end
            S_IDLE: begin
                we.occ    = accept && (i_cmd == CMD_WRITE) && in_grid;
                waddr     = in_addr;
                occ_wdata = i_occupied;
            end
            S_WB: begin
                we.zp   = (r_pass == P_Z);
                we.yp   = (r_pass == P_Y);
                we.dmap = (r_pass == P_X);
            end
            default: ;
        endcase
    end

    ssdt_store #(
        .AW(AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_raddr     (raddr),
        .i_waddr     (waddr),
        .i_we        (we),
        .i_occ_wdata (occ_wdata),
        .i_wdata     (wdata),
        .o_occ       (occ_rd),
        .o_zp        (zp_rd),
        .o_yp        (yp_rd),
        .o_dist      (dist_rd)
    );

    ssdt_min_unit u_min (
        .i_clk       (i_clk),
        .i_clear     ((r_state == S_ACC) && (r_l == '0)),
        .i_init_size (s_axis),
        .i_acc       (r_pv),
        .i_cand      (cand),
        .i_src       (src),
        .i_a         (r_l_d),
        .i_b         (c_axis),
        .o_best      (best)
    );

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_l         = r_l;
        n_pv        = 1'b0;
        n_clr_addr  = r_clr_addr;
        n_done      = 1'b0;
        n_sq        = r_sq;
        n_rad       = r_rad;
        n_rd_inside = r_rd_inside;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_sq  = '0;
                    n_rad = '0;
                    unique case (i_cmd)
                        CMD_WRITE: n_done = 1'b1;
                        CMD_RUN: begin
                            n_pass = P_Z;
                            n_x    = '0;
                            n_y    = '0;
                            n_z    = '0;
                            n_l    = '0;
                            if ((eff_x == '0) || (eff_y == '0) || (eff_z == '0)) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_ACC;
                            end
                        end
                        CMD_READ: begin
                            n_rd_inside = in_grid;
                            n_state     = S_READ;
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_READ: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_rd_inside) begin
                    n_sq  = dist_rd;
                    n_rad = empty_radius(dist_rd);
                end
            end
            S_ACC: begin
                n_pv = 1'b1;
                if (l_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_l = r_l + COORD_W'(1);
                end
            end
            S_DRAIN: n_state = S_WB;
            S_WB: begin
                n_l     = '0;
                n_state = S_ACC;
                if (!z_last) begin
                    n_z = r_z + COORD_W'(1);
                end else begin
                    n_z = '0;
                    if (!y_last) begin
                        n_y = r_y + COORD_W'(1);
                    end else begin
                        n_y = '0;
                        if (!x_last) begin
                            n_x = r_x + COORD_W'(1);
                        end else begin
                            n_x = '0;
                            unique case (r_pass)
                                P_Z: n_pass = P_Y;
                                P_Y: n_pass = P_X;
                                P_X: begin
                                    n_pass  = P_Z;
                                    n_state = S_IDLE;
                                    n_done  = 1'b1;
                                end
                                default: n_pass = P_Z;
                            endcase
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_pass     <= P_Z;
            r_x        <= '0;
            r_y        <= '0;
            r_z        <= '0;
            r_l        <= '0;
            r_pv       <= 1'b0;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pass     <= n_pass;
            r_x        <= n_x;
            r_y        <= n_y;
            r_z        <= n_z;
            r_l        <= n_l;
            r_pv       <= n_pv;
            r_clr_addr <= n_clr_addr;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_l_d       <= r_l;
        r_sq        <= n_sq;
        r_rad       <= n_rad;
        r_rd_inside <= n_rd_inside;
    end

    assign o_done         = r_done;
    assign o_sq_distance  = r_sq;
    assign o_empty_radius = r_rad;

endmodule

// ===== design/ssdt_checker.sv =====
module ssdt_checker
    import ssdt_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [CMD_W-1:0]        i_cmd,
    input logic                    o_done,
    input logic [DIST_W-1:0]       o_sq_distance,
    input logic signed [RAD_W-1:0] o_empty_radius
);

    // clearing pass begins right after reset
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_done)
        else $error("block not busy clearing after reset");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_WRITE))
        |=> o_done && (o_sq_distance == '0) && (o_empty_radius == '0))
        else $error("write transaction result missing or nonzero");

    a_read_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_READ)) |=> busy && !o_done ##1 o_done)
        else $error("read transaction result not on time");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_sq_distance == '0))
        |-> ((o_empty_radius == '0) || (o_empty_radius == -5'sd1)))
        else $error("radius inconsistent with zero distance");

    a_pos_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_sq_distance != '0)) |-> !o_empty_radius[RAD_W-1])
        else $error("negative radius for nonzero distance");

endmodule

bind separable_squared_distance_transform_unit ssdt_checker u_ssdt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_done         (o_done),
    .o_sq_distance  (o_sq_distance),
    .o_empty_radius (o_empty_radius)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import ssdt_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam int                   CELL_COUNT  = COORD_LIM * COORD_LIM * COORD_LIM;
    localparam int                   ITEM_TARGET = 1450;
    localparam int                   RUN_BUDGET  = 6000;
    localparam int                   CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [DIST_W-1:0]       sq;
        logic signed [RAD_W-1:0] rad;
    } dist_readout_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CMD_W-1:0]     cmd;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   z;
        logic                 occ;
        logic [CFG_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]    data;
        logic                 typed;
        dist_readout_t        want;
    } script_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        i_cmd;
    logic [COORD_W-1:0]      i_coord_x;
    logic [COORD_W-1:0]      i_coord_y;
    logic [COORD_W-1:0]      i_coord_z;
    logic                    i_occupied;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [SIZE_W-1:0]       i_cfg_data;
    logic                    o_done;
    logic [DIST_W-1:0]       o_sq_distance;
    logic signed [RAD_W-1:0] o_empty_radius;

    separable_squared_distance_transform_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_occupied     (i_occupied),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_sq_distance  (o_sq_distance),
        .o_empty_radius (o_empty_radius)
    );

    // shadow state of the block
    bit                occupancy_map [CELL_COUNT];
    int                z_column_min  [CELL_COUNT];
    int                y_plane_min   [CELL_COUNT];
    logic [DIST_W-1:0] distance_map  [CELL_COUNT];
    logic [SIZE_W-1:0] grid_size_x;
    logic [SIZE_W-1:0] grid_size_y;
    logic [SIZE_W-1:0] grid_size_z;

    dist_readout_t awaited_readouts [$];
    script_row_t   script [$];
    dist_readout_t head_readout;

    int cycle_count = 0;
    int mismatches  = 0;
    int compared    = 0;
    int items_sent  = 0;
    int writes_sent = 0;
    int runs_sent   = 0;
    int reads_sent  = 0;
    int idle_pct    = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int eff_size(input logic [SIZE_W-1:0] s);
        return (int'(s) > COORD_LIM) ? COORD_LIM : int'(s);
    endfunction

    function automatic int cell_of(input int x, input int y, input int z);
        return (x * COORD_LIM + y) * COORD_LIM + z;
    endfunction

    function automatic bit in_box(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                  input logic [COORD_W-1:0] z);
        return int'(x) < eff_size(grid_size_x) && int'(y) < eff_size(grid_size_y) &&
               int'(z) < eff_size(grid_size_z);
    endfunction

    function automatic int run_cost(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                                    input logic [SIZE_W-1:0] sz);
        int ex;
        int ey;
        int ez;
        ex = eff_size(sx);
        ey = eff_size(sy);
        ez = eff_size(sz);
        return ex * ey * ez * (ex + ey + ez + 6);
    endfunction

    task automatic sweep_distances();
        int sx;
        int sy;
        int sz;
        int best;
        int d;
        sx = eff_size(grid_size_x);
        sy = eff_size(grid_size_y);
        sz = eff_size(grid_size_z);
        for (int x = 0; x < sx; x++)
            for (int y = 0; y < sy; y++)
                for (int z = 0; z < sz; z++) begin
                    best = 0;
                    if (!occupancy_map[cell_of(x, y, z)]) begin
                        best = sz * sz;
                        for (int l = 0; l < sz; l++) begin
                            if (l != z && occupancy_map[cell_of(x, y, l)] &&
                                (l - z) * (l - z) < best) begin
                                best = (l - z) * (l - z);
                            end
                        end
                    end
                    z_column_min[cell_of(x, y, z)] = best;
                end
        for (int x = 0; x < sx; x++)
            for (int y = 0; y < sy; y++)
                for (int z = 0; z < sz; z++) begin
                    best = 0;
                    if (z_column_min[cell_of(x, y, z)] != 0) begin
                        best = sy * sy;
                        for (int l = 0; l < sy; l++) begin
                            d = z_column_min[cell_of(x, l, z)] + (y - l) * (y - l);
                            if (d < best) best = d;
                        end
                    end
                    y_plane_min[cell_of(x, y, z)] = best;
                end
        for (int x = 0; x < sx; x++)
            for (int y = 0; y < sy; y++)
                for (int z = 0; z < sz; z++) begin
                    best = 0;
                    if (y_plane_min[cell_of(x, y, z)] != 0) begin
                        best = sx * sx;
                        for (int l = 0; l < sx; l++) begin
                            d = y_plane_min[cell_of(l, y, z)] + (x - l) * (x - l);
                            if (d < best) best = d;
                        end
                    end
                    distance_map[cell_of(x, y, z)] = DIST_W'(best);
                end
    endtask

    task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                                   input logic occ, output dist_readout_t res);
        int d;
        int root;
        res = '0;
        case (cmd)
            CMD_WRITE: begin
                if (in_box(x, y, z)) occupancy_map[cell_of(x, y, z)] = occ;
            end
            CMD_RUN: begin
                sweep_distances();
            end
            CMD_READ: begin
                if (in_box(x, y, z)) begin
                    d = int'(distance_map[cell_of(x, y, z)]);
                    root = 0;
                    while ((root + 1) * (root + 1) <= d) root++;
                    res.sq  = DIST_W'(d);
                    res.rad = RAD_W'(root - 1);
                end
            end
            default: ;
        endcase
    endtask

    function automatic script_row_t cmd_row(input logic [CMD_W-1:0] cmd,
                                            input int x, input int y, input int z,
                                            input logic occ, input logic typed,
                                            input int sq, input int rad);
        script_row_t row;
        row          = '0;
        row.cmd      = cmd;
        row.x        = COORD_W'(x);
        row.y        = COORD_W'(y);
        row.z        = COORD_W'(z);
        row.occ      = occ;
        row.typed    = typed;
        row.want.sq  = DIST_W'(sq);
        row.want.rad = RAD_W'(rad);
        return row;
    endfunction

    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        script_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = SIZE_W'(data);
        return row;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int extent);
        if (extent == 0 || $urandom_range(99) < 15) return COORD_W'($urandom_range(15));
        return COORD_W'($urandom_range(extent - 1));
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return SIZE_W'($urandom_range(31, 16));
        if (r < 30) return SIZE_W'($urandom_range(15, 6));
        return SIZE_W'($urandom_range(5, 1));
    endfunction

    // hold start low until the block has drained, then write one size register
    task automatic program_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        start <= 1'b0;
        while (awaited_readouts.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SIZE_X: grid_size_x = data;
            CFG_SIZE_Y: grid_size_y = data;
            CFG_SIZE_Z: grid_size_z = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                         input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                         input logic occ, input logic typed, input dist_readout_t want);
        dist_readout_t predicted;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_coord_x  <= x;
        i_coord_y  <= y;
        i_coord_z  <= z;
        i_occupied <= occ;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        items_sent++;
        if (cmd == CMD_RUN) begin
            runs_sent++;
        end else if (cmd == CMD_WRITE && in_box(x, y, z)) begin
            writes_sent++;
        end else if (cmd == CMD_READ && in_box(x, y, z)) begin
            reads_sent++;
        end
        predict_command(cmd, x, y, z, occ, predicted);
        awaited_readouts.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("separable_squared_distance_transform_unit verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) begin
            if (awaited_readouts.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transaction: sq_distance %0d empty_radius %0d",
                         $time, o_sq_distance, o_empty_radius);
            end else begin
                head_readout = awaited_readouts.pop_front();
                compared++;
                if (o_sq_distance !== head_readout.sq) begin
                    mismatches++;
                    $display("%0t: sq_distance expected %0d actual %0d",
                             $time, head_readout.sq, o_sq_distance);
                end
                if (o_empty_radius !== head_readout.rad) begin
                    mismatches++;
                    $display("%0t: empty_radius expected %0d actual %0d",
                             $time, head_readout.rad, o_empty_radius);
                end
            end
        end
    end

    initial begin
        script_row_t       row;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
        int                rounds;
        int                count;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = CMD_WRITE;
        i_coord_x  = '0;
        i_coord_y  = '0;
        i_coord_z  = '0;
        i_occupied = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_SIZE_X;
        i_cfg_data = '0;
        grid_size_x = SIZE_RESET;
        grid_size_y = SIZE_RESET;
        grid_size_z = SIZE_RESET;
        for (int i = 0; i < CELL_COUNT; i++) begin
            occupancy_map[i] = 1'b0;
            z_column_min[i]  = 0;
            y_plane_min[i]   = 0;
            distance_map[i]  = '0;
        end

        // empty full grid first, so a run saturates every voxel at the top of the range
        script.push_back(cmd_row(CMD_READ, 0, 0, 0, 1'b0, 1'b1, 0, -1));
        script.push_back(cmd_row(CMD_READ, 15, 15, 15, 1'b1, 1'b1, 0, -1));
        script.push_back(cmd_row(CMD_SPARE, 15, 15, 15, 1'b1, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_RUN, 0, 0, 0, 1'b0, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_READ, 0, 0, 0, 1'b0, 1'b1, 256, 15));
        script.push_back(cmd_row(CMD_READ, 15, 15, 15, 1'b0, 1'b1, 256, 15));
        script.push_back(cmd_row(CMD_WRITE, 0, 0, 0, 1'b1, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_WRITE, 15, 15, 15, 1'b1, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_READ, 0, 0, 0, 1'b0, 1'b1, 256, 15));
        script.push_back(cfg_row(CFG_SIZE_X, 3));
        script.push_back(cfg_row(CFG_SIZE_Y, 2));
        script.push_back(cfg_row(CFG_SIZE_Z, 5));
        script.push_back(cfg_row(CFG_SPARE, 1));
        script.push_back(cmd_row(CMD_WRITE, 2, 1, 4, 1'b1, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_WRITE, 3, 0, 0, 1'b1, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_RUN, 0, 0, 0, 1'b0, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_READ, 1, 1, 2, 1'b0, 1'b0, 0, 0));
        script.push_back(cmd_row(CMD_READ, 2, 0, 4, 1'b0, 1'b0, 0, 0));
        script.push_back(cmd_row(CMD_READ, 3, 0, 0, 1'b0, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_READ, 15, 15, 15, 1'b0, 1'b1, 0, 0));
        script.push_back(cfg_row(CFG_SIZE_X, 0));
        script.push_back(cmd_row(CMD_WRITE, 0, 0, 0, 1'b0, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_RUN, 0, 0, 0, 1'b0, 1'b1, 0, 0));
        script.push_back(cmd_row(CMD_READ, 0, 0, 0, 1'b0, 1'b1, 0, 0));
        script.push_back(cfg_row(CFG_SIZE_X, 31));
        script.push_back(cfg_row(CFG_SIZE_Y, 1));
        script.push_back(cfg_row(CFG_SIZE_Z, 1));
        script.push_back(cmd_row(CMD_WRITE, 15, 0, 0, 1'b1, 1'b0, 0, 0));
        script.push_back(cmd_row(CMD_RUN, 0, 0, 0, 1'b0, 1'b0, 0, 0));
        script.push_back(cmd_row(CMD_READ, 7, 0, 0, 1'b0, 1'b0, 0, 0));
        script.push_back(cmd_row(CMD_READ, 15, 0, 0, 1'b0, 1'b0, 0, 0));
        script.push_back(cmd_row(CMD_READ, 0, 0, 0, 1'b0, 1'b0, 0, 0));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            row = script[i];
            if (row.is_cfg) program_size(row.idx, row.data);
            else issue(row.cmd, row.x, row.y, row.z, row.occ, row.typed, row.want);
        end

        // random scenes: fill some voxels, run, probe, with noise mixed in
        while (items_sent < ITEM_TARGET) begin
            idle_pct = (items_sent < ITEM_TARGET / 3) ? 18 :
                       (items_sent < 2 * ITEM_TARGET / 3) ? 87 : 0;
            do begin
                sx = pick_size();
                sy = pick_size();
                sz = pick_size();
            end while (run_cost(sx, sy, sz) > RUN_BUDGET);
            program_size(CFG_SIZE_X, sx);
            program_size(CFG_SIZE_Y, sy);
            program_size(CFG_SIZE_Z, sz);
            rounds = ($urandom_range(99) < 35) ? 2 : 1;
            for (int r = 0; r < rounds; r++) begin
                count = $urandom_range(14, 2);
                for (int k = 0; k < count; k++) begin
                    if ($urandom_range(99) < 8)
                        issue(CMD_W'($urandom_range(3)), COORD_W'($urandom_range(15)),
                              COORD_W'($urandom_range(15)), COORD_W'($urandom_range(15)),
                              1'($urandom_range(1)), 1'b0, '0);
                    else
                        issue(CMD_WRITE, pick_coord(eff_size(sx)), pick_coord(eff_size(sy)),
                              pick_coord(eff_size(sz)), $urandom_range(99) < 35, 1'b0, '0);
                end
                if ($urandom_range(99) >= 5)
                    issue(CMD_RUN, COORD_W'($urandom_range(15)), COORD_W'($urandom_range(15)),
                          COORD_W'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, '0);
                count = $urandom_range(16, 4);
                for (int k = 0; k < count; k++) begin
                    if ($urandom_range(99) < 8)
                        issue(CMD_W'($urandom_range(3)), COORD_W'($urandom_range(15)),
                              COORD_W'($urandom_range(15)), COORD_W'($urandom_range(15)),
                              1'($urandom_range(1)), 1'b0, '0);
                    else
                        issue(CMD_READ, pick_coord(eff_size(sx)), pick_coord(eff_size(sy)),
                              pick_coord(eff_size(sz)), 1'($urandom_range(1)), 1'b0, '0);
                end
            end
        end

        start <= 1'b0;
        while (awaited_readouts.size() != 0) @(negedge i_clk);
        repeat (16) @(posedge i_clk);
        if (awaited_readouts.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected transactions never arrived",
                     $time, awaited_readouts.size());
        end

        $display("exercised %0d occupancy writes, %0d transform runs, %0d voxel reads in box",
                 writes_sent, runs_sent, reads_sent);
        $display("%0d transactions sent, %0d compared, %0d mismatches",
                 items_sent, compared, mismatches);
        if (mismatches == 0) begin
            $display("separable_squared_distance_transform_unit verification clean");
        end else begin
            $display("separable_squared_distance_transform_unit verification failed");
        end
        $finish;
    end

endmodule
